// File: hw/rtl/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg: shared types and constants for the Modbus ASCII deframer
// Transaction payloads, result kinds, character codes and frame state.
// ----------------------------------------------------------------------------
`default_nettype none

package mad_pkg;

    // Frame size limit and timeout defaults
    localparam int unsigned MAX_FRAME_CHARS_DEF = 256;
    localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;
    localparam logic [15:0] TICK_SAT            = 16'hFFFF;
    localparam logic [7:0]  COUNT_SAT           = 8'hFF;

    // Input opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Character codes
    localparam logic [7:0] CH_START = 8'h3A;  // ':'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_F     = 8'h46;  // 'F'
    localparam logic [7:0] HEX_A_OFFSET = 8'h0A;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    // Input transaction
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_char;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [7:0] byte_count;
        logic       last;
    } out_item_t;

    // Frame state with fixed widths (the character count lives apart)
    typedef struct packed {
        logic        in_frame;
        logic [3:0]  held_nibble;
        logic        nibble_phase;
        logic [7:0]  lrc_sum;
        logic [7:0]  decoded_count;
        logic        cr_seen;
        logic        frame_error;
        logic [15:0] tick_count;
    } frame_state_t;

    localparam frame_state_t FRAME_CLEAR = '{
        in_frame:      1'b0,
        held_nibble:   4'd0,
        nibble_phase:  1'b0,
        lrc_sum:       8'd0,
        decoded_count: 8'd0,
        cr_seen:       1'b0,
        frame_error:   1'b0,
        tick_count:    16'd0
    };

endpackage : mad_pkg

`default_nettype wire

// File: hw/rtl/modbus_ascii_deframer_top.sv
// ----------------------------------------------------------------------------
// modbus_ascii_deframer_top: Modbus ASCII frame receiver
// Turns a character/tick stream into data bytes and frame status results.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  --------  ----------------------  -----------------------------------------
//  in        in_valid / in_stall     in_data  (opcode, rx_char)
//  out       out_valid / out_stall   out_data (kind, data_byte, byte_count, last)
//  cfg       cfg_wr_en               cfg_wr_data (timeout_ticks)
//
//  One transaction per cycle while the result queue has space: an item waits in
//  the input register, then the frame state and the result queue update together.
//  A result passes the input register and then the result queue before it
//  shows on out_valid; it is taken on an edge where out_stall is low.
//  The two-entry result queue holds up to two results while the output stalls;
//  the input stalls only when the queue is full and an item waits in the input
//  register.
//  Reset clears frame state and sets timeout_ticks to 1000.
//
`default_nettype none

module modbus_ascii_deframer_top
    import mad_pkg::*;
#(
    parameter int unsigned MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF
)(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_stall,
    input  var in_item_t in_data,
    output logic       out_valid,
    input  wire        out_stall,
    output out_item_t  out_data,
    input  wire        cfg_wr_en,
    input  wire [15:0] cfg_wr_data
);

    localparam int unsigned CHAR_W = $clog2(MAX_FRAME_CHARS + 1);

    logic              s1_valid_reg, s1_valid_next;
    in_item_t          s1_item_reg;
    frame_state_t      st_reg, st_next;
    logic [CHAR_W-1:0] char_count_reg, char_count_next;
    logic [15:0]       timeout_reg;
    logic              res_valid;
    out_item_t         res;
    logic              q_space;
    logic              advance;
    logic              accept;

    // Handshake control
    assign advance  = s1_valid_reg && q_space;
    assign in_stall = s1_valid_reg && !q_space;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Frame state and timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= FRAME_CLEAR;
            char_count_reg <= '0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            if (advance)
            begin
                st_reg         <= st_next;
                char_count_reg <= char_count_next;
            end
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
        end
    end

    mad_step #(
        .MAX_FRAME_CHARS (MAX_FRAME_CHARS),
        .CHAR_W          (CHAR_W)
    ) u_step (
        .item            (s1_item_reg),
        .st              (st_reg),
        .char_count      (char_count_reg),
        .timeout_ticks   (timeout_reg),
        .st_next         (st_next),
        .char_count_next (char_count_next),
        .res_valid       (res_valid),
        .res             (res)
    );

    mad_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance && res_valid),
        .push_data (res),
        .space     (q_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule : modbus_ascii_deframer_top

`default_nettype wire

// File: hw/rtl/mad_step.sv
// ----------------------------------------------------------------------------
// mad_step: next-state and result logic for one character or tick
// Decodes hex pairs, tracks CR/LF, LRC sum, character limit and timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module mad_step
    import mad_pkg::*;
#(
    parameter int unsigned MAX_FRAME_CHARS = MAX_FRAME_CHARS_DEF,
    parameter int unsigned CHAR_W          = $clog2(MAX_FRAME_CHARS + 1)
)(
    input  var in_item_t     item,
    input  var frame_state_t st,
    input  wire [CHAR_W-1:0] char_count,
    input  wire [15:0]       timeout_ticks,
    output frame_state_t     st_next,
    output logic [CHAR_W-1:0] char_count_next,
    output logic             res_valid,
    output out_item_t        res
);

    localparam logic [CHAR_W-1:0] CHAR_LIMIT = CHAR_W'(MAX_FRAME_CHARS);
    localparam logic [CHAR_W-1:0] CHAR_ONE   = CHAR_W'(1);

    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [7:0]  char_sub;
    logic [15:0] tick_inc;
    logic [7:0]  byte_val;
    logic        frame_good;

    // Decode one upper-case hex digit
    always_comb
    begin
        hex_ok   = 1'b0;
        char_sub = 8'd0;
        if (item.rx_char >= CH_ZERO && item.rx_char <= CH_NINE)
        begin
            hex_ok   = 1'b1;
            char_sub = item.rx_char - CH_ZERO;
        end
        else if (item.rx_char >= CH_A && item.rx_char <= CH_F)
        begin
            hex_ok   = 1'b1;
            char_sub = item.rx_char - CH_A + HEX_A_OFFSET;
        end
        hex_val = char_sub[3:0];
    end

    assign tick_inc   = (st.tick_count != TICK_SAT) ? st.tick_count + 16'd1 : st.tick_count;
    assign byte_val   = {st.held_nibble, hex_val};
    assign frame_good = !st.frame_error && !st.nibble_phase &&
                        (st.decoded_count != 8'd0) && (st.lrc_sum == 8'd0);

    // Advance frame state and form the result
    always_comb
    begin
        st_next         = st;
        char_count_next = char_count;
        res_valid       = 1'b0;
        res             = '{kind: KIND_DATA, data_byte: 8'd0, byte_count: 8'd0, last: 1'b0};

        if (item.opcode == OP_TICK)
        begin
            // Count idle ticks, abort on timeout
            if (st.in_frame && timeout_ticks != 16'd0)
            begin
                st_next.tick_count = tick_inc;
                if (tick_inc >= timeout_ticks)
                begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_ABORT;
                    res.byte_count  = st.decoded_count;
                    res.last        = 1'b1;
                    st_next         = FRAME_CLEAR;
                    char_count_next = '0;
                end
            end
        end
        else if (item.rx_char == CH_START)
        begin
            // Drop any open frame and start a new one
            st_next          = FRAME_CLEAR;
            st_next.in_frame = 1'b1;
            char_count_next  = CHAR_ONE;
        end
        else if (st.in_frame)
        begin
            st_next.tick_count = 16'd0;
            if (char_count >= CHAR_LIMIT)
            begin
                // Character limit reached: abort
                res_valid       = 1'b1;
                res.kind        = KIND_ABORT;
                res.byte_count  = st.decoded_count;
                res.last        = 1'b1;
                st_next         = FRAME_CLEAR;
                char_count_next = '0;
            end
            else
            begin
                char_count_next = char_count + CHAR_ONE;
                if (item.rx_char == CH_LF)
                begin
                    if (st.cr_seen)
                    begin
                        // End of frame
                        res_valid       = 1'b1;
                        res.kind        = frame_good ? KIND_GOOD : KIND_BAD;
                        res.byte_count  = st.decoded_count;
                        res.last        = 1'b1;
                        st_next         = FRAME_CLEAR;
                        char_count_next = '0;
                    end
                    else
                    begin
                        st_next.frame_error = 1'b1;
                    end
                end
                else if (st.cr_seen && item.rx_char == CH_CR)
                begin
                    // Stray CR keeps the CR flag
                    st_next.frame_error = 1'b1;
                end
                else
                begin
                    // CR not followed by LF
                    if (st.cr_seen)
                    begin
                        st_next.frame_error = 1'b1;
                        st_next.cr_seen     = 1'b0;
                    end

                    if (item.rx_char == CH_CR)
                    begin
                        st_next.cr_seen = 1'b1;
                    end
                    else if (!hex_ok)
                    begin
                        st_next.frame_error = 1'b1;
                    end
                    else if (!st.nibble_phase)
                    begin
                        st_next.held_nibble  = hex_val;
                        st_next.nibble_phase = 1'b1;
                    end
                    else
                    begin
                        // Second digit completes a byte
                        st_next.nibble_phase = 1'b0;
                        st_next.held_nibble  = 4'd0;
                        st_next.lrc_sum      = st.lrc_sum + byte_val;
                        if (st.decoded_count != COUNT_SAT)
                        begin
                            st_next.decoded_count = st.decoded_count + 8'd1;
                        end
                        res_valid     = 1'b1;
                        res.kind      = KIND_DATA;
                        res.data_byte = byte_val;
                    end
                end
            end
        end
    end

endmodule : mad_step

`default_nettype wire

// File: hw/rtl/mad_outq.sv
// ----------------------------------------------------------------------------
// mad_outq: two-entry result queue
// Holds results so the pipeline keeps moving while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module mad_outq
    import mad_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        push,
    input  var out_item_t push_data,
    output logic       space,
    output logic       out_valid,
    input  wire        out_stall,
    output out_item_t  out_data
);

    out_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign space     = (count_reg != 2'd2);
    assign pop       = out_valid && !out_stall;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule : mad_outq

`default_nettype wire
